>>> design/pgs_pkg.sv
// ---------------------------------------------------------------------------
// pgs_pkg
// Shared types, constants and helper functions of the palette gradient
// sampler: palette ROM contents, widths, register indexes and the /255 helper.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pgs_pkg;

    // Channel and beat widths
    localparam int CH_W  = 8;
    localparam int POS_W = 8;
    localparam int PIX_W = 3 * CH_W;

    // Palette geometry
    localparam int NUM_PALETTES        = 8;
    localparam int COLOURS_PER_PALETTE = 8;
    localparam int PAL_W   = (NUM_PALETTES > 1) ? $clog2(NUM_PALETTES) : 1;
    localparam int COL_W   = $clog2(COLOURS_PER_PALETTE);
    localparam int RAM_DEPTH = NUM_PALETTES * COLOURS_PER_PALETTE;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    // Built-in table geometry
    localparam int ROM_PALETTES = 8;
    localparam int ROM_COLOURS  = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SELECT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS     = 1'd1;
    localparam logic [CH_W-1:0]      BRIGHTNESS_RESET   = 8'd255;

    // Palette RAM write beat
    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [PIX_W-1:0]  data;
    } t_ram_wr;

    // Per-channel blend sums (red at index 0)
    typedef logic [2:0][2*CH_W-1:0] t_mix3;

    // Pack one color: red in the low byte
    function automatic logic [PIX_W-1:0] rgb(input int r, input int g, input int b);
        return {8'(b), 8'(g), 8'(r)};
    endfunction

    localparam logic [PIX_W-1:0] GRAD_ROM [ROM_PALETTES*ROM_COLOURS] = '{
        rgb(0,195,255),   rgb(115,230,255), rgb(90,55,255),   rgb(175,145,255),
        rgb(245,35,185),  rgb(255,145,220), rgb(0,220,145),   rgb(120,255,205),
        rgb(0,35,135),    rgb(80,125,220),  rgb(0,100,235),   rgb(100,175,255),
        rgb(0,205,220),   rgb(105,245,245), rgb(0,175,120),   rgb(110,230,190),
        rgb(215,20,85),   rgb(255,125,170), rgb(255,70,25),   rgb(255,155,105),
        rgb(255,145,0),   rgb(255,205,95),  rgb(255,215,0),   rgb(255,240,125),
        rgb(0,125,145),   rgb(85,205,215),  rgb(0,225,205),   rgb(105,255,235),
        rgb(50,220,70),   rgb(145,255,150), rgb(255,180,0),   rgb(255,220,100),
        rgb(0,70,55),     rgb(75,145,125),  rgb(0,155,80),    rgb(95,220,145),
        rgb(95,145,0),    rgb(175,210,80),  rgb(185,225,0),   rgb(225,250,100),
        rgb(210,0,15),    rgb(255,105,100), rgb(255,45,0),    rgb(255,135,90),
        rgb(255,110,0),   rgb(255,185,80),  rgb(255,190,0),   rgb(255,230,105),
        rgb(35,45,175),   rgb(115,135,235), rgb(115,70,220),  rgb(185,145,250),
        rgb(215,75,205),  rgb(250,165,235), rgb(255,140,105), rgb(255,205,170),
        rgb(0,85,255),    rgb(100,165,255), rgb(155,20,255),  rgb(210,125,255),
        rgb(255,0,135),   rgb(255,120,195), rgb(165,255,0),   rgb(215,255,110)
    };

    // Slots outside the built-in table read as black
    function automatic logic [PIX_W-1:0] rom_word(input int pal, input int col);
        if (pal < ROM_PALETTES && col < ROM_COLOURS)
            return GRAD_ROM[pal*ROM_COLOURS + col];
        return '0;
    endfunction

    // Exact floor(x/255) for x up to 255*255
    function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
        logic [2*CH_W:0] t;
        t = 17'(x) + 17'd1 + 17'(x[2*CH_W-1:CH_W]);
        return t[2*CH_W-1:CH_W];
    endfunction

endpackage

`default_nettype wire

>>> design/palette_gradient_sampler_top.sv
// ---------------------------------------------------------------------------
// palette_gradient_sampler_top
// Samples a cyclic palette gradient: looks up two neighboring colors in the
// palette RAM, blends them by the position's fraction and dims the result.
//
//  Channel  Dir  Signals                    Beat contents
//  s_axis   in   tvalid/tready/tdata[7:0]   position
//  m_axis   out  tvalid/tready/tdata[23:0]  red, green, blue levels
//  cfg      in   we/idx/data[7:0]           0 palette_select, 1 brightness
//
// One beat per cycle sustained while the output is not stalled; each beat passes
// through the registered RAM read, blend, /255 and brightness multiply, final /255.
// After reset a pass over all 64 entries loads the palette RAM from the built-in table;
// s_axis tready stays low until it ends.
// The pipeline advances as a whole when the output register is empty or taken;
// a stalled output beat freezes every stage and the RAM read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module palette_gradient_sampler_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [7:0]                    i_s_axis_tdata,   // [7:0] position
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [23:0]                        o_m_axis_tdata,   // [7:0] red_level,
                                                                 // [15:8] green_level,
                                                                 // [23:16] blue_level
    input  wire logic                          i_cfg_we,
    input  wire logic [pgs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [7:0]                    i_cfg_data
);
    import pgs_pkg::*;

    logic [CH_W-1:0]   r_palette_select;
    logic [CH_W-1:0]   r_brightness;
    logic              r_s1_vld;
    logic [CH_W-1:0]   r_s1_weight;

    t_ram_wr           fill_wr;
    logic              fill_done;
    logic              adv;
    logic              accept;
    logic [PAL_W-1:0]  pal_idx;
    logic [15:0]       scaled;
    logic [COL_W-1:0]  col_idx;
    logic [COL_W-1:0]  col_nxt;
    logic [RAM_AW-1:0] addr_a;
    logic [RAM_AW-1:0] addr_b;
    logic [PIX_W-1:0]  color_a;
    logic [PIX_W-1:0]  color_b;
    logic              mix_vld;
    t_mix3             mix;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_palette_select <= '0;
            r_brightness     <= BRIGHTNESS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PALETTE_SELECT: r_palette_select <= i_cfg_data;
                CFG_BRIGHTNESS:     r_brightness     <= i_cfg_data;
                default:            ;
            endcase
        end
    end

    // Handshake: whole pipeline moves when the output slot frees up
    assign adv             = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = adv && fill_done;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Color index, blend weight and RAM addresses
    always_comb begin
        pal_idx = PAL_W'(r_palette_select % NUM_PALETTES);
        scaled  = 16'(i_s_axis_tdata * COLOURS_PER_PALETTE);
        col_idx = COL_W'(scaled[15:8]);
        col_nxt = (col_idx == COL_W'(COLOURS_PER_PALETTE - 1))
                ? '0 : col_idx + COL_W'(1);
        addr_a  = RAM_AW'(pal_idx * COLOURS_PER_PALETTE + col_idx);
        addr_b  = RAM_AW'(pal_idx * COLOURS_PER_PALETTE + col_nxt);
    end

    // Stage 1: weight travels beside the RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_weight <= scaled[7:0];
        end
    end

    pgs_fill u_fill (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_wr    (fill_wr),
        .o_done  (fill_done)
    );

    pgs_ram #(
        .WIDTH (PIX_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (fill_wr.we),
        .i_waddr   (fill_wr.addr),
        .i_wdata   (fill_wr.data),
        .i_re      (adv),
        .i_raddr_a (addr_a),
        .i_raddr_b (addr_b),
        .o_rdata_a (color_a),
        .o_rdata_b (color_b)
    );

    pgs_blend u_blend (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_vld     (r_s1_vld),
        .i_weight  (r_s1_weight),
        .i_color_a (color_a),
        .i_color_b (color_b),
        .o_vld     (mix_vld),
        .o_mix     (mix)
    );

    pgs_dim u_dim (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_vld        (mix_vld),
        .i_mix        (mix),
        .i_brightness (r_brightness),
        .o_vld        (o_m_axis_tvalid),
        .o_pixel      (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> design/pgs_ram.sv
// ---------------------------------------------------------------------------
// pgs_ram
// Generic RAM: one write port, two read ports with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports, data held while read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> design/pgs_fill.sv
// ---------------------------------------------------------------------------
// pgs_fill
// Loads the palette RAM from the built-in table after reset, one entry a cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgs_fill (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    output pgs_pkg::t_ram_wr     o_wr,
    output logic                 o_done
);
    import pgs_pkg::*;

    logic [RAM_AW-1:0] r_addr;
    logic [PAL_W-1:0]  r_pal;
    logic [COL_W-1:0]  r_col;
    logic              r_done;

    // Sweep counters: address plus palette/color pair
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_pal  <= '0;
            r_col  <= '0;
            r_done <= 1'b0;
        end else if (!r_done) begin
            r_addr <= r_addr + RAM_AW'(1);
            if (r_addr == RAM_AW'(RAM_DEPTH - 1)) begin
                r_done <= 1'b1;
            end
            if (r_col == COL_W'(COLOURS_PER_PALETTE - 1)) begin
                r_col <= '0;
                r_pal <= r_pal + PAL_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    always_comb begin
        o_wr.we   = !r_done;
        o_wr.addr = r_addr;
        o_wr.data = rom_word(int'(r_pal), int'(r_col));
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

>>> design/pgs_blend.sv
// ---------------------------------------------------------------------------
// pgs_blend
// Blend stage: weighs the two neighboring palette colors per channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgs_blend (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic                       i_vld,
    input  wire logic [pgs_pkg::CH_W-1:0]   i_weight,
    input  wire logic [pgs_pkg::PIX_W-1:0]  i_color_a,
    input  wire logic [pgs_pkg::PIX_W-1:0]  i_color_b,
    output logic                            o_vld,
    output pgs_pkg::t_mix3                  o_mix
);
    import pgs_pkg::*;

    logic  r_vld;
    t_mix3 r_mix;
    t_mix3 n_mix;

    // a*(255-w) + b*w per channel, at most 255*255
    always_comb begin
        logic [CH_W-1:0] inv_w;
        inv_w = 8'd255 - i_weight;
        for (int c = 0; c < 3; c++) begin
            n_mix[c] = 16'(i_color_a[c*CH_W +: CH_W]) * 16'(inv_w)
                     + 16'(i_color_b[c*CH_W +: CH_W]) * 16'(i_weight);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mix <= n_mix;
        end
    end

    assign o_vld = r_vld;
    assign o_mix = r_mix;

endmodule

`default_nettype wire

>>> design/pgs_dim.sv
// ---------------------------------------------------------------------------
// pgs_dim
// Normalizes the blend by 255, scales by brightness and holds the output beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgs_dim (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic                       i_vld,
    input  wire pgs_pkg::t_mix3             i_mix,
    input  wire logic [pgs_pkg::CH_W-1:0]   i_brightness,
    output logic                            o_vld,
    output logic [pgs_pkg::PIX_W-1:0]       o_pixel
);
    import pgs_pkg::*;

    logic             r_prod_vld;
    t_mix3            r_prod;
    t_mix3            n_prod;
    logic             r_out_vld;
    logic [PIX_W-1:0] r_pixel;
    logic [PIX_W-1:0] n_pixel;

    // Blend / 255, then times brightness
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_prod[c] = 16'(div255(i_mix[c])) * 16'(i_brightness);
        end
    end

    // Dimmed level / 255
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_pixel[c*CH_W +: CH_W] = div255(r_prod[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else if (i_adv) begin
            r_prod_vld <= i_vld;
            r_out_vld  <= r_prod_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_prod  <= n_prod;
            r_pixel <= n_pixel;
        end
    end

    assign o_vld   = r_out_vld;
    assign o_pixel = r_pixel;

endmodule

`default_nettype wire
